// ----- rtl/m3inv_pkg.sv -----
// m3inv_pkg: types and constants shared by the 3x3 matrix inverse
// no dependencies
package m3inv_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int ELEM_BITS_DEF = 32;
  localparam int THR_BITS      = 31;
  localparam int N_ELEM        = 9;

  typedef struct packed {
    logic signed [ELEM_BITS_DEF-1:0] m11;
    logic signed [ELEM_BITS_DEF-1:0] m12;
    logic signed [ELEM_BITS_DEF-1:0] m13;
    logic signed [ELEM_BITS_DEF-1:0] m21;
    logic signed [ELEM_BITS_DEF-1:0] m22;
    logic signed [ELEM_BITS_DEF-1:0] m23;
    logic signed [ELEM_BITS_DEF-1:0] m31;
    logic signed [ELEM_BITS_DEF-1:0] m32;
    logic signed [ELEM_BITS_DEF-1:0] m33;
  } in_beat_t;

  typedef struct packed {
    logic signed [ELEM_BITS_DEF-1:0] r11;
    logic signed [ELEM_BITS_DEF-1:0] r12;
    logic signed [ELEM_BITS_DEF-1:0] r13;
    logic signed [ELEM_BITS_DEF-1:0] r21;
    logic signed [ELEM_BITS_DEF-1:0] r22;
    logic signed [ELEM_BITS_DEF-1:0] r23;
    logic signed [ELEM_BITS_DEF-1:0] r31;
    logic signed [ELEM_BITS_DEF-1:0] r32;
    logic signed [ELEM_BITS_DEF-1:0] r33;
    logic                            singular;
    logic                            saturated;
  } out_beat_t;

  typedef struct packed {
    logic sing;
    logic dneg;
  } lane_ctl_t;

endpackage

// ----- rtl/m3inv_div.sv -----
// m3inv_div: pipelined restoring divider, one quotient bit per stage
// depends on nothing; lane of the inverse core
module m3inv_div #(
  parameter int NW = 97,
  parameter int DW = 96,
  parameter int TW = 2
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag,
  output logic [NW-1:0] quo,
  output logic [TW-1:0] tag_q
);

  logic [DW:0]   rem [NW+1];
  logic [NW-1:0] nq  [NW+1];
  logic [DW-1:0] dd  [NW+1];
  logic [TW-1:0] tg  [NW+1];

  assign rem[0] = '0;
  assign nq[0]  = num;
  assign dd[0]  = den;
  assign tg[0]  = tag;

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW+1:0] sh;
    logic [DW+1:0] df;
    logic [DW:0]   rn;
    logic [NW-1:0] qn;
    always_comb begin
      sh = {rem[s], nq[s][NW-1]};
      df = sh - {2'b00, dd[s]};
      rn = df[DW+1] ? sh[DW:0] : df[DW:0];
      qn = {nq[s][NW-2:0], ~df[DW+1]};
    end
    always_ff @(posedge clk) begin
      rem[s+1] <= rn;
      nq[s+1]  <= qn;
      dd[s+1]  <= dd[s];
      tg[s+1]  <= tg[s];
    end
  end

  assign quo   = nq[NW];
  assign tag_q = tg[NW];

endmodule

// ----- rtl/m3inv_front.sv -----
// m3inv_front: cofactors and determinant, registered stages
// depends on m3inv_pkg
module m3inv_front #(
  parameter int EW = m3inv_pkg::ELEM_BITS_DEF,
  parameter int FW = m3inv_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic [9*EW-1:0]      mat,
  input  logic [m3inv_pkg::THR_BITS-1:0] thr,
  output logic [9*(2*EW+1)-1:0] cof,
  output logic [3*EW+2:0]      det_mag,
  output logic                 det_neg,
  output logic                 sing
);

  localparam int CW  = 2*EW + 1;
  localparam int TW  = CW + EW;
  localparam int DTW = 3*EW + 3;
  localparam int THR_BITS_L = m3inv_pkg::THR_BITS;

  // explicit cofactor operand lists
  localparam int OX [9] = '{4,5,3,2,0,1,1,2,0};
  localparam int OY [9] = '{8,6,7,7,8,6,5,3,4};
  localparam int OU [9] = '{5,3,4,1,2,0,2,0,1};
  localparam int OV [9] = '{7,8,6,8,6,7,4,5,3};

  logic signed [EW-1:0]   a    [9];
  logic signed [2*EW-1:0] p    [18];
  logic signed [CW-1:0]   c    [9];
  logic signed [CW-1:0]   c2   [9];
  logic signed [CW-1:0]   c3   [9];
  logic signed [CW-1:0]   ph   [3];
  logic signed [CW-1:0]   pl   [3];
  logic signed [TW-1:0]   t    [3];
  logic signed [EW-1:0]   mreg [3];
  logic signed [EW-1:0]   m2   [3];
  logic [THR_BITS_L-1:0]  thr1, thr2, thr3, thr4;
  logic [DTW-1:0]         dmag_c;
  logic signed [DTW-1:0]  det_c;

  always_comb begin
    for (int i = 0; i < 9; i++) a[i] = mat[(8-i)*EW +: EW];
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      p[2*k]   <= a[OX[k]] * a[OY[k]];
      p[2*k+1] <= a[OU[k]] * a[OV[k]];
    end
    for (int i = 0; i < 3; i++) mreg[i] <= a[i];
    thr1 <= thr;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++)
      c[k] <= CW'(p[2*k]) - CW'(p[2*k+1]);
    for (int i = 0; i < 3; i++) m2[i] <= mreg[i];
    thr2 <= thr1;
  end

  // first-row products split into high and low halves of the cofactor
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ph[i] <= m2[i] * $signed(c[i][CW-1:EW]);
      pl[i] <= m2[i] * $signed({1'b0, c[i][EW-1:0]});
    end
    for (int k = 0; k < 9; k++) c2[k] <= c[k];
    thr3 <= thr2;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) t[i] <= (TW'(ph[i]) <<< EW) + TW'(pl[i]);
    for (int k = 0; k < 9; k++) c3[k] <= c2[k];
    thr4 <= thr3;
  end

  always_comb begin
    det_c  = DTW'(t[0]) + DTW'(t[1]) + DTW'(t[2]);
    dmag_c = det_c[DTW-1] ? DTW'(-det_c) : DTW'(det_c);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) cof[k*CW +: CW] <= c3[k];
    det_mag <= dmag_c;
    det_neg <= det_c[DTW-1];
    sing    <= dmag_c <= (DTW'(thr4) << (2*FW));
  end

endmodule

// ----- rtl/m3inv_lane.sv -----
// m3inv_lane: one output element: magnitude divide, round and saturate
// depends on m3inv_pkg, m3inv_div
module m3inv_lane #(
  parameter int EW = m3inv_pkg::ELEM_BITS_DEF,
  parameter int FW = m3inv_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic signed [2*EW:0] cof,
  input  logic [3*EW+2:0]     det_mag,
  input  logic                det_neg,
  output logic [EW-1:0]       res,
  output logic                clip
);

  localparam int CW = 2*EW + 1;
  localparam int NW = CW + 2*FW + 1;
  localparam int DW = 3*EW + 3;

  logic [CW-1:0] cmag;
  logic [NW-1:0] num, quo;
  logic [0:0]    ng, ng_q;

  always_comb begin
    cmag  = cof[CW-1] ? CW'(-cof) : CW'(cof);
    num   = NW'(cmag) << (2*FW + 1);
    ng[0] = cof[CW-1] ^ det_neg;
  end

  m3inv_div #(.NW(NW), .DW(DW), .TW(1)) u_div (
    .clk(clk), .num(num), .den(det_mag), .tag(ng), .quo(quo), .tag_q(ng_q)
  );

  logic [NW:0] q1;
  logic        neg;
  logic        ovf;
  always_comb begin
    q1  = ({1'b0, quo} + (NW+1)'(1)) >> 1;
    neg = ng_q[0] && (q1 != '0);
    ovf = neg ? (q1 > ((NW+1)'(1) << (EW-1))) : (q1 >= ((NW+1)'(1) << (EW-1)));
  end

  always_ff @(posedge clk) begin
    clip <= ovf;
    if (ovf) res <= neg ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
    else     res <= neg ? EW'(-q1[EW-1:0]) : q1[EW-1:0];
  end

endmodule

// ----- rtl/matrix3_inverse_top.sv -----
// matrix3_inverse_top: 3x3 fixed-point matrix inverse by adjugate
// depends on m3inv_pkg, m3inv_front, m3inv_lane, m3inv_div
//
// channel   dir  handshake           payload
// cmd       in   start / busy        m (in_beat_t)
// cfg       in   cfg_valid/cfg_ready cfg_data (threshold)
// result    out  done strobe         r (out_beat_t)
//
// one matrix accepted every cycle; busy stays low outside reset
// the path runs through 5 front stages, 2*ELEM+2*FRAC+2 divider stages, then the lane and merge registers;
// the divider stages come from the nine lanes of bit-per-stage dividers
// synchronous reset clears the valid pipeline and the threshold
// the receiver cannot stall; done is a one-cycle strobe
module matrix3_inverse_top #(
  parameter int FRAC_BITS = m3inv_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  m3inv_pkg::in_beat_t  m,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [m3inv_pkg::THR_BITS-1:0] cfg_data,
  output logic                 done,
  output m3inv_pkg::out_beat_t r
);

  localparam int EW  = m3inv_pkg::ELEM_BITS_DEF;
  localparam int CW  = 2*EW + 1;
  localparam int NW  = CW + 2*FRAC_BITS + 1;
  localparam int LAT = 5 + NW + 2;
  localparam int PK [9] = '{0,3,6,1,4,7,2,5,8};

  logic [m3inv_pkg::THR_BITS-1:0] thr;
  logic [LAT-1:0] vpipe;
  logic [LAT-7:0] spipe;

  assign busy      = rst;
  assign cfg_ready = ~rst;

  always_ff @(posedge clk) begin
    if (rst) thr <= '0;
    else if (cfg_valid && cfg_ready) thr <= cfg_data;
  end

  logic            sing;
  logic [9*CW-1:0] cof;
  logic [3*EW+2:0] dmag;
  logic            dneg;

  m3inv_front #(.EW(EW), .FW(FRAC_BITS)) u_front (
    .clk(clk), .mat(m), .thr(thr),
    .cof(cof), .det_mag(dmag), .det_neg(dneg), .sing(sing)
  );

  logic [EW-1:0] res [9];
  logic [8:0]    clip;
  for (genvar i = 0; i < 9; i++) begin : g_lane
    m3inv_lane #(.EW(EW), .FW(FRAC_BITS)) u_lane (
      .clk(clk), .cof(cof[PK[i]*CW +: CW]),
      .det_mag(sing ? {{(3*EW+2){1'b0}}, 1'b1} : dmag),
      .det_neg(dneg), .res(res[i]), .clip(clip[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) vpipe <= '0;
    else     vpipe <= {vpipe[LAT-2:0], start & ~busy};
    spipe <= {spipe[LAT-8:0], sing};
  end

  // merge lanes
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vpipe[LAT-2];
    r.r11 <= spipe[LAT-7] ? '0 : res[0];
    r.r12 <= spipe[LAT-7] ? '0 : res[1];
    r.r13 <= spipe[LAT-7] ? '0 : res[2];
    r.r21 <= spipe[LAT-7] ? '0 : res[3];
    r.r22 <= spipe[LAT-7] ? '0 : res[4];
    r.r23 <= spipe[LAT-7] ? '0 : res[5];
    r.r31 <= spipe[LAT-7] ? '0 : res[6];
    r.r32 <= spipe[LAT-7] ? '0 : res[7];
    r.r33 <= spipe[LAT-7] ? '0 : res[8];
    r.singular  <= spipe[LAT-7];
    r.saturated <= ~spipe[LAT-7] & (|clip);
  end

endmodule
